>>> rtl/core/multi_context_interval_timer_unit_macros.svh
// Assertion macros shared by the interval timer RTL
`ifndef MULTI_CONTEXT_INTERVAL_TIMER_UNIT_MACROS_SVH
`define MULTI_CONTEXT_INTERVAL_TIMER_UNIT_MACROS_SVH

// same-cycle implication under reset
`define MCIT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication under reset
`define MCIT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/mcit_pkg.sv
// Types, codes and constants of the interval timer bank
`timescale 1ns / 1ps
`default_nettype none
package mcit_pkg;

   localparam int NUM_CONTEXTS_DEF = 4;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [3:0] OFS_STATUS  = 4'h0;
   localparam logic [3:0] OFS_CONTROL = 4'h4;
   localparam logic [3:0] OFS_PERIOD  = 4'h8;
   localparam logic [3:0] OFS_COUNT   = 4'hC;

   localparam int ST_TO    = 0;
   localparam int ST_RUN   = 1;
   localparam int CT_ITO   = 0;
   localparam int CT_CONT  = 1;
   localparam int CT_START = 2;
   localparam int CT_STOP  = 3;

   localparam logic [31:0] CT_WR_MASK = 32'h0000_000F;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [1:0]  context_req;
      logic [3:0]  reg_offset;
      logic [31:0] write_data;
      logic [63:0] tick_time;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq;
   } rsp_type;

   // only the low word of the time stamp matters: elapsed time wraps at 32 bits
   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  control;
      logic [31:0] period;
      logic [31:0] count;
      logic [31:0] last_time;
      logic        irq_pending;
   } ctx_state_type;

   localparam int STATE_W = $bits(ctx_state_type);

endpackage
`default_nettype wire

>>> rtl/core/multi_context_interval_timer_unit.sv
// Top level of the multi-context interval timer bank
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  mcit_pkg::req_type (write, read, tick)
//  rsp      out        rsp_valid / rsp_ready  mcit_pkg::rsp_type (read data, irq)
//
//  One word per cycle while rsp is not stalled; each word passes a state RAM read, then
//  update, write-back and the result register.
//  A word on the same context as its predecessor takes the forwarded state.
//  Reset clears the per-context valid bits at once; an unwritten context reads as zero.
//  A stalled rsp holds the result; one more word is still taken into the update stage.
`timescale 1ns / 1ps
`default_nettype none
module multi_context_interval_timer_unit #(
   parameter int NUM_CONTEXTS = mcit_pkg::NUM_CONTEXTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mcit_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mcit_pkg::rsp_type      rsp_data
);
   import mcit_pkg::*;

   `include "multi_context_interval_timer_unit_macros.svh"

   localparam int IDX_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

   logic                  req_acc;
   logic [IDX_W-1:0]      rd_idx;
   logic                  rd_hit;

   logic                  s1_valid_ff, s1_valid_in;
   req_type               s1_req_ff;
   logic                  s1_hit_ff;
   logic                  s1_adv;
   logic [IDX_W-1:0]      s1_idx;

   logic [NUM_CONTEXTS-1:0] valid_ff, valid_in;
   logic                  rd_valid_ff;
   logic                  fwd_ff;
   ctx_state_type         fwd_data_ff;

   logic [STATE_W-1:0]    ram_q;
   logic                  ram_we;

   ctx_state_type         cur;
   ctx_state_type         nxt;
   rsp_type               res;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff;

   assign req_acc = req_valid && req_ready;
   assign rd_idx  = IDX_W'(req_data.context_req);
   assign rd_hit  = (32'(req_data.context_req) < NUM_CONTEXTS);
   assign s1_idx  = IDX_W'(s1_req_ff.context_req);

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign ram_we    = s1_adv && s1_hit_ff;

   mcit_ram #(
      .WIDTH (STATE_W),
      .DEPTH (NUM_CONTEXTS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_idx),
      .wr_data (nxt),
      .rd_en   (req_acc),
      .rd_addr (rd_idx),
      .rd_data (ram_q)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ram_we) begin
         valid_in[s1_idx] = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // update stage: pick current state, apply the word
   always_comb begin
      logic [31:0] now_lo;
      logic [31:0] c_raw;
      logic [31:0] reload;
      logic        expired;
      logic        run;

      if (fwd_ff) begin
         cur = fwd_data_ff;
      end else if (rd_valid_ff) begin
         cur = ctx_state_type'(ram_q);
      end else begin
         cur = '0;
      end

      nxt     = cur;
      res     = '0;
      now_lo  = s1_req_ff.tick_time[31:0];
      c_raw   = 32'd0;
      reload  = 32'd0;
      expired = 1'b0;
      run     = 1'b0;

      if (s1_hit_ff) begin
         case (s1_req_ff.opcode)
            OP_WRITE: begin
               case (s1_req_ff.reg_offset)
                  OFS_STATUS: begin
                     if (!s1_req_ff.write_data[ST_TO]) begin
                        nxt.status[ST_TO] = 1'b0;
                     end
                     if (!nxt.status[ST_TO]) begin
                        nxt.irq_pending = 1'b0;
                     end
                  end
                  OFS_CONTROL: begin
                     nxt.control = 4'(s1_req_ff.write_data & CT_WR_MASK);
                  end
                  OFS_PERIOD: begin
                     nxt.period = s1_req_ff.write_data;
                     nxt.count  = s1_req_ff.write_data;
                  end
                  default: begin
                  end
               endcase
            end
            OP_READ: begin
               case (s1_req_ff.reg_offset)
                  OFS_STATUS:  res.read_data = 32'(cur.status);
                  OFS_CONTROL: res.read_data = 32'(cur.control);
                  OFS_PERIOD:  res.read_data = cur.period;
                  OFS_COUNT:   res.read_data = cur.count;
                  default:     res.read_data = 32'd0;
               endcase
            end
            OP_TICK: begin
               run = cur.status[ST_RUN];
               if (!run && cur.control[CT_START]) begin
                  nxt.control[CT_START] = 1'b0;
                  run                   = 1'b1;
                  nxt.last_time         = now_lo;
               end
               if (run && nxt.control[CT_STOP]) begin
                  nxt.control[CT_STOP] = 1'b0;
                  run                  = 1'b0;
               end
               // count minus elapsed, and period minus overrun, side by side
               c_raw   = cur.count + nxt.last_time - now_lo;
               reload  = cur.period + cur.count + nxt.last_time - now_lo;
               expired = c_raw[31] || (c_raw == 32'd0);
               if (run) begin
                  nxt.last_time = now_lo;
                  if (expired) begin
                     nxt.status[ST_TO] = 1'b1;
                     if (nxt.control[CT_CONT]) begin
                        nxt.count = reload;
                     end else begin
                        nxt.count = 32'd0;
                        run       = 1'b0;
                     end
                  end else begin
                     nxt.count = c_raw;
                  end
               end
               nxt.status[ST_RUN] = run;
               if (nxt.control[CT_ITO] && nxt.status[ST_TO] && !cur.irq_pending) begin
                  res.irq         = 1'b1;
                  nxt.irq_pending = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         fwd_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         if (req_acc) begin
            fwd_ff <= ram_we && (s1_idx == rd_idx);
         end else if (s1_adv) begin
            fwd_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_req_ff   <= req_data;
         s1_hit_ff   <= rd_hit;
         rd_valid_ff <= valid_ff[rd_idx];
         fwd_data_ff <= nxt;
      end
      if (s1_adv) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MCIT_ASSERT_SAME(a_we_needs_item, clock, reset, ram_we, s1_valid_ff && s1_hit_ff, "state write without an item in the update stage")
   `MCIT_ASSERT_SAME(a_fwd_needs_item, clock, reset, fwd_ff, s1_valid_ff, "forwarded state without an item")
   `MCIT_ASSERT_SAME(a_stall_cause, clock, reset, !req_ready, s1_valid_ff && rsp_valid_ff && !rsp_ready, "input stalled without a blocked result")
   `MCIT_ASSERT_NEXT(a_irq_only_tick, clock, reset, s1_adv && (s1_req_ff.opcode != OP_TICK), !rsp_data_ff.irq, "interrupt on a word that is not a tick")
   `MCIT_ASSERT_NEXT(a_irq_sets_pending, clock, reset, ram_we && res.irq, valid_ff[$past(s1_idx)], "interrupt raised without the context marked written")

endmodule
`default_nettype wire

>>> rtl/core/mcit_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module mcit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire
